// ===== sv/mlqs_pkg.sv =====
// Package: types and constants for the multilevel queue scheduler.
package mlqs_pkg;

   localparam int MAX_PROCS_DEF  = 16;
   localparam int NUM_QUEUES_DEF = 4;
   localparam int PID_W          = 4;
   localparam int QID_W          = 2;
   localparam int BURST_W        = 16;
   localparam int TIME_W         = 32;
   localparam int CSR_IDX_W      = 2;
   localparam int CSR_DATA_W     = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_QUEUES   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POLICIES = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SLICES   = 2'd2;

   localparam logic OP_ARRIVE = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   localparam logic [1:0] POL_RR    = 2'd0;
   localparam logic [1:0] POL_SJF   = 2'd1;
   localparam logic [1:0] POL_SRTN  = 2'd2;
   localparam logic [1:0] POL_SPARE = 2'd3;   // treated as round robin

   typedef struct packed {
      logic                opcode;
      logic [PID_W-1:0]    proc_id;
      logic [QID_W-1:0]    queue_id;
      logic [BURST_W-1:0]  burst;
   } req_type;

   typedef struct packed {
      logic [TIME_W-1:0]   tick_time;
      logic                busy_res;
      logic [PID_W-1:0]    ran_proc;
      logic [QID_W-1:0]    ran_queue;
      logic                finished;
      logic                all_done;
   } rsp_type;

   // start/busy/done control bundle; no module in this project uses this type
   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } scan_ctl_type;

endpackage

// ===== sv/mlqs_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
module mlqs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/multilevel_queue_scheduler.sv =====
// Top level: multilevel queue scheduler with sequencer over shared RAMs and one comparator.
//
// Usage:
//   req_ channel: raise start with req_data; the beat is taken when start is high and
//   busy is low. Opcode 0 is an arrival (proc, queue, burst), opcode 1 a time tick.
//   rsp_ channel: each tick yields one result beat, shown on rsp_data for one cycle
//   with rsp_valid high. The receiver cannot stall; it must take the beat.
//   csr_ port: csr_we, csr_idx, csr_wdata write queues_in_use (0), queue_policies (1)
//   or queue_slices (2), one per write; write only while busy is low.
// Sequencing:
//   An arrival keeps busy high for 1 cycle after its accepting edge. A tick walks ready
//   lists through one RAM read port and one shared 16-bit comparator; each list entry
//   takes a pid read, then a remaining-time read, and removal shifts one entry at a
//   time. The result beat appears in the cycle busy drops.
// Reset:
//   Synchronous active-high reset clears counts, flags, run state and time; the
//   RAM contents are left undefined and are read only below the counts.
module multilevel_queue_scheduler
   import mlqs_pkg::*;
#(
   parameter int MAX_PROCS  = MAX_PROCS_DEF,
   parameter int NUM_QUEUES = NUM_QUEUES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_idx,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int PW  = $clog2(MAX_PROCS);
   localparam int QW  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int CW  = $clog2(MAX_PROCS + 1);
   localparam int EW  = QW + PW;
   localparam int ED  = 2 ** EW;
   localparam int NQW = $clog2(NUM_QUEUES + 1);

   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_ARR    = 5'd1;
   localparam logic [4:0] S_PRE0   = 5'd2;
   localparam logic [4:0] S_SCAN_A = 5'd3;
   localparam logic [4:0] S_SCAN_B = 5'd4;
   localparam logic [4:0] S_SCAN_C = 5'd5;
   localparam logic [4:0] S_PRE1   = 5'd6;
   localparam logic [4:0] S_PRE2   = 5'd7;
   localparam logic [4:0] S_DISP   = 5'd8;
   localparam logic [4:0] S_REM_A  = 5'd9;
   localparam logic [4:0] S_REM_B  = 5'd10;
   localparam logic [4:0] S_RUN0   = 5'd11;
   localparam logic [4:0] S_RUN1   = 5'd12;
   localparam logic [4:0] S_QUANT  = 5'd13;
   localparam logic [4:0] S_OUT    = 5'd14;
   localparam logic [4:0] S_APP    = 5'd15;
   localparam logic [4:0] S_RT_A   = 5'd16;
   localparam logic [4:0] S_RT_B   = 5'd17;

   // config
   logic [2:0]  qin_ff;
   logic [7:0]  pol_ff;
   logic [31:0] slc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         qin_ff <= 3'd4;
         pol_ff <= 8'd0;
         slc_ff <= 32'h0404_0404;
      end else if (csr_we) begin
         case (csr_idx)
            CSR_QUEUES:   qin_ff <= csr_wdata[2:0];
            CSR_POLICIES: pol_ff <= csr_wdata[7:0];
            CSR_SLICES:   slc_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic [NQW-1:0] nq;
   always_comb begin
      if (qin_ff == 3'd0) begin
         nq = NQW'(1);
      end else if (32'(qin_ff) > NUM_QUEUES) begin
         nq = NQW'(NUM_QUEUES);
      end else begin
         nq = NQW'(qin_ff);
      end
   end

   function automatic logic [1:0] pol_of(input logic [7:0] p, input logic [QW-1:0] q);
      logic [1:0] r;
      r = 2'd0;
      if (32'(q) < 4) begin
         r = 2'(p >> (2 * int'(q)));
      end
      return r;
   endfunction

   function automatic logic [7:0] slc_of(input logic [31:0] s, input logic [QW-1:0] q);
      logic [7:0] r;
      r = 8'd0;
      if (32'(q) < 4) begin
         r = 8'(s >> (8 * int'(q)));
      end
      return r;
   endfunction

   // state
   logic [4:0]     st_ff, st_in;
   logic [MAX_PROCS-1:0] act_ff, act_in;
   logic [CW-1:0]  cnt_ff [NUM_QUEUES];
   logic [CW-1:0]  cnt_in [NUM_QUEUES];
   logic [PW-1:0]  rp_ff, rp_in;
   logic           rv_ff, rv_in;
   logic [QW-1:0]  crq_ff, crq_in;
   logic           rqv_ff, rqv_in;
   logic [QW-1:0]  rot_ff, rot_in;
   logic [7:0]     qu_ff, qu_in;
   logic [TIME_W-1:0] tm_ff, tm_in;
   // work registers
   req_type        rq_ff, rq_in;
   logic [QW-1:0]  sq_ff, sq_in;       // queue being scanned
   logic [NQW-1:0] si_ff, si_in;       // rotation step
   logic [QW-1:0]  rm_ff, rm_in;       // rotation start reduced below the queue count
   logic [CW-1:0]  pos_ff, pos_in;     // list position
   logic [CW-1:0]  best_ff, best_in;
   logic [BURST_W-1:0] bt_ff, bt_in;   // best remaining time
   logic [PW-1:0]  bp_ff, bp_in;       // best pid
   logic           pre_ff, pre_in;     // scan is for preemption
   logic [BURST_W-1:0] rrt_ff, rrt_in; // running proc remaining
   logic [PW-1:0]  ap_ff, ap_in;       // pid to append after removal
   logic           apv_ff, apv_in;
   logic           ov_ff, ov_in;
   rsp_type        od_ff, od_in;

   // memories
   logic           ew, rw;
   logic [EW-1:0]  ewa, era;
   logic [PW-1:0]  ewd, erd;
   logic [PW-1:0]  rwa, rra;
   logic [BURST_W-1:0] rwd, rrd;

   mlqs_ram #(.WIDTH(PW), .DEPTH(ED)) u_entries (
      .clock(clock), .wr_en(ew), .wr_addr(ewa), .wr_data(ewd),
      .rd_addr(era), .rd_data(erd)
   );

   mlqs_ram #(.WIDTH(BURST_W), .DEPTH(MAX_PROCS)) u_remain (
      .clock(clock), .wr_en(rw), .wr_addr(rwa), .wr_data(rwd),
      .rd_addr(rra), .rd_data(rrd)
   );

   function automatic logic [EW-1:0] ea(input logic [QW-1:0] q, input logic [CW-1:0] p);
      return {q, p[PW-1:0]};
   endfunction

   // shared comparator
   logic [BURST_W-1:0] cmp_a, cmp_b;
   logic               cmp_lt;
   assign cmp_lt = cmp_a < cmp_b;

   logic [CW-1:0] scnt;
   logic [NQW-1:0] rot_sum;
   logic [QW-1:0]  rot_nxt;

   always_comb begin
      st_in = st_ff; act_in = act_ff; cnt_in = cnt_ff;
      rp_in = rp_ff; rv_in = rv_ff; crq_in = crq_ff; rqv_in = rqv_ff;
      rot_in = rot_ff; qu_in = qu_ff; tm_in = tm_ff; rq_in = rq_ff;
      sq_in = sq_ff; si_in = si_ff; rm_in = rm_ff; pos_in = pos_ff; best_in = best_ff;
      bt_in = bt_ff; bp_in = bp_ff; pre_in = pre_ff; rrt_in = rrt_ff;
      ap_in = ap_ff; apv_in = apv_ff; ov_in = 1'b0; od_in = od_ff;
      ew = 1'b0; ewa = ea(sq_ff, pos_ff); ewd = erd;
      rw = 1'b0; rwa = rp_ff; rwd = rrt_ff;
      era = ea(sq_ff, pos_ff); rra = erd;
      cmp_a = rrd; cmp_b = bt_ff;
      scnt = cnt_ff[sq_ff];
      rot_sum = NQW'(rm_ff) + si_ff;
      rot_nxt = (rot_sum >= nq) ? QW'(rot_sum - nq) : QW'(rot_sum);
      case (st_ff)
         S_IDLE: begin
            if (start) begin
               rq_in = req_data;
               if (req_data.opcode == OP_ARRIVE) begin
                  st_in = S_ARR;
               end else begin
                  st_in = S_PRE0;
               end
            end
         end
         S_ARR: begin
            if (32'(rq_ff.queue_id) < 32'(nq) && 32'(rq_ff.proc_id) < MAX_PROCS
                && rq_ff.burst != '0 && !act_ff[PW'(rq_ff.proc_id)]) begin
               act_in[PW'(rq_ff.proc_id)] = 1'b1;
               rw = 1'b1; rwa = PW'(rq_ff.proc_id); rwd = rq_ff.burst;
               ew = 1'b1;
               ewa = ea(QW'(rq_ff.queue_id), cnt_ff[QW'(rq_ff.queue_id)]);
               ewd = PW'(rq_ff.proc_id);
               cnt_in[QW'(rq_ff.queue_id)] = cnt_ff[QW'(rq_ff.queue_id)] + 1'b1;
            end
            st_in = S_IDLE;
         end
         S_PRE0: begin
            // fetch running remaining time, then decide on preemption scan
            rra = rp_ff;
            si_in = '0;
            rm_in = rot_ff;
            if (rv_ff && rqv_ff && pol_of(pol_ff, crq_ff) == POL_SRTN
                && cnt_ff[crq_ff] != '0) begin
               pre_in = 1'b1; sq_in = crq_ff; pos_in = '0;
               st_in = S_RT_A;
            end else begin
               pre_in = 1'b0;
               st_in = S_DISP;
            end
         end
         S_RT_A: begin
            rrt_in = rrd;
            era = ea(sq_ff, '0);
            st_in = S_SCAN_A;
         end
         S_DISP: begin
            // rotation step si_ff
            if (NQW'(rm_ff) >= nq) begin
               rm_in = QW'(NQW'(rm_ff) - nq);
            end else if (rv_ff) begin
               st_in = S_RUN0;
            end else if (si_ff >= nq) begin
               st_in = S_QUANT;
            end else begin
               sq_in = rot_nxt;
               scnt = cnt_ff[rot_nxt];
               if (scnt == '0) begin
                  si_in = si_ff + 1'b1;
               end else begin
                  rot_in = rot_nxt;
                  rm_in = rot_nxt;
                  pos_in = '0;
                  best_in = '0;
                  era = ea(rot_nxt, '0);
                  if (pol_of(pol_ff, rot_nxt) == POL_SJF
                      || pol_of(pol_ff, rot_nxt) == POL_SRTN) begin
                     st_in = S_SCAN_A;
                  end else begin
                     st_in = S_SCAN_C;
                  end
               end
            end
         end
         S_SCAN_A: begin
            // erd holds pid at pos_ff; read its remaining time
            rra = erd;
            bp_in = (pos_ff == '0) ? erd : bp_ff;
            ap_in = erd;
            st_in = S_SCAN_B;
         end
         S_SCAN_B: begin
            cmp_a = rrd; cmp_b = bt_ff;
            if (pos_ff == '0 || cmp_lt) begin
               bt_in = rrd; best_in = pos_ff; bp_in = ap_ff;
            end
            if (pos_ff + 1'b1 < cnt_ff[sq_ff]) begin
               pos_in = pos_ff + 1'b1;
               era = ea(sq_ff, pos_ff + 1'b1);
               st_in = S_SCAN_A;
            end else if (pre_ff) begin
               st_in = S_PRE1;
            end else begin
               st_in = S_SCAN_C;
            end
         end
         S_SCAN_C: begin
            // dispatch chosen entry: FIFO head (erd) or best
            if (pol_of(pol_ff, sq_ff) == POL_SJF || pol_of(pol_ff, sq_ff) == POL_SRTN) begin
               rp_in = bp_ff;
               pos_in = best_ff;
            end else begin
               rp_in = erd;
               pos_in = '0;
            end
            rv_in = 1'b1;
            if (!rqv_ff || crq_ff != sq_ff) begin
               qu_in = '0;
            end
            crq_in = sq_ff; rqv_in = 1'b1;
            apv_in = 1'b0;
            era = ea(sq_ff, (pol_of(pol_ff, sq_ff) == POL_SJF
                   || pol_of(pol_ff, sq_ff) == POL_SRTN) ? best_ff + 1'b1 : CW'(1));
            st_in = S_REM_A;
         end
         S_PRE1: begin
            cmp_a = bt_ff; cmp_b = rrt_ff;
            if (cmp_lt) begin
               ap_in = rp_ff; apv_in = 1'b1;
               rp_in = bp_ff;
               pos_in = best_ff;
               era = ea(sq_ff, best_ff + 1'b1);
               st_in = S_REM_A;
            end else begin
               st_in = S_DISP;
            end
         end
         S_REM_A: begin
            // shift entries down: entry pos+1 is being read
            era = ea(sq_ff, pos_ff + 1'b1);
            st_in = S_REM_B;
            if (pos_ff + 1'b1 >= cnt_ff[sq_ff]) begin
               cnt_in[sq_ff] = cnt_ff[sq_ff] - 1'b1;
               st_in = apv_ff ? S_APP : S_RUN0;
            end
         end
         S_REM_B: begin
            ew = 1'b1; ewa = ea(sq_ff, pos_ff); ewd = erd;
            pos_in = pos_ff + 1'b1;
            era = ea(sq_ff, pos_ff + 2'd2);
            st_in = S_REM_A;
         end
         S_APP: begin
            ew = 1'b1; ewa = ea(sq_ff, cnt_ff[sq_ff]); ewd = ap_ff;
            cnt_in[sq_ff] = cnt_ff[sq_ff] + 1'b1;
            apv_in = 1'b0;
            st_in = S_DISP;
         end
         S_RUN0: begin
            rra = rp_ff;
            st_in = S_RUN1;
         end
         S_RUN1: begin
            rw = 1'b1; rwa = rp_ff; rwd = rrd - 1'b1;
            od_in.busy_res = 1'b1;
            od_in.ran_proc = PID_W'(rp_ff);
            od_in.ran_queue = QID_W'(crq_ff);
            od_in.finished = 1'b0;
            if (rrd == BURST_W'(1)) begin
               od_in.finished = 1'b1;
               act_in[rp_ff] = 1'b0;
               rv_in = 1'b0;
            end
            st_in = S_QUANT;
         end
         S_QUANT: begin
            if (rqv_ff) begin
               qu_in = qu_ff + 1'b1;
               if (qu_ff + 1'b1 >= slc_of(slc_ff, crq_ff)) begin
                  if (rv_ff) begin
                     ew = 1'b1; ewa = ea(crq_ff, cnt_ff[crq_ff]); ewd = rp_ff;
                     cnt_in[crq_ff] = cnt_ff[crq_ff] + 1'b1;
                     rv_in = 1'b0;
                  end
                  rot_in = (NQW'(rm_ff) + 1'b1 >= nq) ? '0 : rm_ff + 1'b1;
                  rqv_in = 1'b0;
               end
            end
            st_in = S_OUT;
         end
         S_OUT: begin
            ov_in = 1'b1;
            od_in.tick_time = tm_ff;
            od_in.all_done = (act_ff == '0);
            tm_in = tm_ff + 1'b1;
            st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
      if (st_ff == S_PRE0 || (st_ff == S_IDLE && start)) begin
         od_in.busy_res = 1'b0; od_in.ran_proc = '0;
         od_in.ran_queue = '0; od_in.finished = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; act_ff <= '0;
         for (int i = 0; i < NUM_QUEUES; i++) cnt_ff[i] <= '0;
         rp_ff <= '0; rv_ff <= 1'b0; crq_ff <= '0; rqv_ff <= 1'b0;
         rot_ff <= '0; qu_ff <= '0; tm_ff <= '0; ov_ff <= 1'b0;
         apv_ff <= 1'b0; pre_ff <= 1'b0; si_ff <= '0;
      end else begin
         st_ff <= st_in; act_ff <= act_in; cnt_ff <= cnt_in;
         rp_ff <= rp_in; rv_ff <= rv_in; crq_ff <= crq_in; rqv_ff <= rqv_in;
         rot_ff <= rot_in; qu_ff <= qu_in; tm_ff <= tm_in; ov_ff <= ov_in;
         apv_ff <= apv_in; pre_ff <= pre_in; si_ff <= si_in;
      end
      rq_ff <= rq_in; sq_ff <= sq_in; pos_ff <= pos_in; best_ff <= best_in;
      bt_ff <= bt_in; bp_ff <= bp_in; rrt_ff <= rrt_in; ap_ff <= ap_in;
      od_ff <= od_in; rm_ff <= rm_in;
   end

   assign busy      = (st_ff != S_IDLE);
   assign rsp_valid = ov_ff;
   assign rsp_data  = od_ff;

`ifndef SYNTHESIS
   a_rsp_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$past(rsp_valid)) else $error("result beat repeated");
   a_busy_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.busy_res) |-> rsp_data.all_done == 1'b0
      || rsp_data.finished) else $error("ran with nothing active");
   a_idle_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.busy_res) |-> (rsp_data.ran_proc == '0
      && !rsp_data.finished)) else $error("idle tick reports process");
   a_arrival_quiet: assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_ARR) |=> !rsp_valid) else $error("arrival produced result");
`endif

endmodule

// ===== test/tb.sv =====
// Testbench for the multilevel queue scheduler: directed and random arrivals and ticks.
module tb;
   import mlqs_pkg::*;

   localparam int NPROC = 16;
   localparam int NQ = 4;
   localparam int WATCHDOG_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_data = '0;
   logic rsp_valid;
   rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_idx = CSR_QUEUES;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   multilevel_queue_scheduler i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_we(csr_we), .csr_idx(csr_idx),
      .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   // scheduler shadow state
   logic [2:0]  sh_nq_reg;
   logic [7:0]  sh_pol;
   logic [31:0] sh_slice;
   logic [15:0] rem_time [NPROC];
   logic        active [NPROC];
   logic [3:0]  rdy [NQ][NPROC];
   int          rdy_cnt [NQ];
   logic [3:0]  run_pid;
   logic        run_ok;
   logic [1:0]  run_q;
   logic        run_q_ok;
   logic [1:0]  rot;
   logic [7:0]  used;
   logic [31:0] now;

   rsp_type tick_results [$];
   int mismatches = 0;
   int ticks_seen = 0;
   int idle_pct = 29;
   int idle_cycles = 0;
   bit timed_out = 0;

   function automatic int nq_eff();
      if (sh_nq_reg < 1) return 1;
      if (sh_nq_reg > NQ) return NQ;
      return sh_nq_reg;
   endfunction

   function automatic int shortest_pos(int q);
      int b;
      b = 0;
      for (int i = 1; i < rdy_cnt[q]; i++)
         if (rem_time[rdy[q][i]] < rem_time[rdy[q][b]]) b = i;
      return b;
   endfunction

   function automatic void pull(int q, int pos);
      for (int i = pos; i + 1 < rdy_cnt[q]; i++) rdy[q][i] = rdy[q][i+1];
      rdy_cnt[q]--;
   endfunction

   function automatic void push(int q, logic [3:0] p);
      if (rdy_cnt[q] < NPROC) begin
         rdy[q][rdy_cnt[q]] = p;
         rdy_cnt[q]++;
      end
   endfunction

   function automatic void sched_reset();
      sh_nq_reg = 3'd4; sh_pol = 8'h00; sh_slice = 32'h04040404;
      for (int i = 0; i < NPROC; i++) begin active[i] = 0; rem_time[i] = '0; end
      for (int q = 0; q < NQ; q++) rdy_cnt[q] = 0;
      run_pid = '0; run_ok = 0; run_q = '0; run_q_ok = 0; rot = '0; used = '0; now = '0;
   endfunction

   function automatic void schedule(req_type r);
      rsp_type o;
      int n, idx, pos, b;
      logic [1:0] pol;
      logic [3:0] tmp;
      if (r.opcode == OP_ARRIVE) begin
         if (r.queue_id >= nq_eff() || r.burst == 0 || active[r.proc_id]) return;
         active[r.proc_id] = 1;
         rem_time[r.proc_id] = r.burst;
         push(r.queue_id, r.proc_id);
         return;
      end
      if (run_ok && run_q_ok && sh_pol[2*run_q +: 2] == POL_SRTN && rdy_cnt[run_q] > 0) begin
         b = shortest_pos(run_q);
         tmp = rdy[run_q][b];
         if (rem_time[tmp] < rem_time[run_pid]) begin
            pull(run_q, b);
            push(run_q, run_pid);
            run_pid = tmp;
         end
      end
      if (!run_ok) begin
         n = nq_eff();
         for (int i = 0; i < n; i++) begin
            idx = (rot + i) % n;
            if (rdy_cnt[idx] == 0) continue;
            rot = 2'(idx);
            pol = sh_pol[2*idx +: 2];
            pos = (pol == POL_SJF || pol == POL_SRTN) ? shortest_pos(idx) : 0;
            run_pid = rdy[idx][pos];
            pull(idx, pos);
            run_ok = 1;
            if (!run_q_ok || run_q != idx) used = '0;
            run_q = 2'(idx);
            run_q_ok = 1;
            break;
         end
      end
      o = '0;
      o.tick_time = now;
      if (run_ok) begin
         o.busy_res = 1; o.ran_proc = run_pid; o.ran_queue = run_q;
         rem_time[run_pid]--;
         if (rem_time[run_pid] == 0) begin
            o.finished = 1; active[run_pid] = 0; run_ok = 0;
         end
      end
      if (run_q_ok) begin
         used = used + 8'd1;
         if (used >= sh_slice[8*run_q +: 8]) begin
            if (run_ok) begin push(run_q, run_pid); run_ok = 0; end
            rot = 2'((rot + 1) % nq_eff());
            run_q_ok = 0;
         end
      end
      o.all_done = 1;
      for (int i = 0; i < NPROC; i++) if (active[i]) o.all_done = 0;
      tick_results = {tick_results, o};
      now = now + 1;
   endfunction

   // result checker
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid) begin
         ticks_seen++;
         if (tick_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected beat %p", rsp_data);
         end else begin
            e = tick_results.pop_front();
            if (e !== rsp_data) begin
               mismatches++;
               if (mismatches <= 10) $display("beat mismatch: expected %p actual %p", e, rsp_data);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
         timed_out = 1;
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic send(logic op, logic [3:0] p, logic [1:0] q, logic [15:0] b);
      req_type r;
      r.opcode = op; r.proc_id = p; r.queue_id = q; r.burst = b;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      schedule(r);
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (tick_results.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] v);
      drain();
      csr_we <= 1'b1; csr_idx <= idx; csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_QUEUES) sh_nq_reg = v[2:0];
      else if (idx == CSR_POLICIES) sh_pol = v[7:0];
      else if (idx == CSR_SLICES) sh_slice = v;
   endtask

   task automatic test_directed();
      send(OP_TICK, 0, 0, 0);
      send(OP_ARRIVE, 4'd15, 2'd3, 16'hFFFF);
      send(OP_ARRIVE, 4'd0, 2'd0, 16'd2);
      send(OP_ARRIVE, 4'd0, 2'd1, 16'd5);
      send(OP_ARRIVE, 4'd1, 2'd1, 16'd0);
      send(OP_ARRIVE, 4'd2, 2'd1, 16'd1);
      send(OP_ARRIVE, 4'd3, 2'd2, 16'd3);
      repeat (8) send(OP_TICK, 0, 0, 0);
      drain();
      sched_flush();
   endtask

   // ticks until no short process is left; long bursts stay active
   task automatic sched_flush();
      int guard;
      guard = 0;
      while (guard < 400) begin
         bit any;
         any = 0;
         for (int i = 0; i < NPROC; i++) if (active[i] && rem_time[i] < 300) any = 1;
         if (!any) break;
         send(OP_TICK, 0, 0, 0);
         guard++;
      end
   endtask

   task automatic test_policies();
      write_reg(CSR_POLICIES, {24'd0, POL_RR, POL_SRTN, POL_SJF, POL_SPARE});
      write_reg(CSR_SLICES, 32'h00_01_03_FF);
      for (int i = 0; i < 6; i++) send(OP_ARRIVE, 4'(i), 2'(i % 4), 16'(6 - i));
      repeat (4) send(OP_TICK, 0, 0, 0);
      send(OP_ARRIVE, 4'd9, 2'd1, 16'd1);
      send(OP_ARRIVE, 4'd10, 2'd2, 16'd1);
      sched_flush();
   endtask

   task automatic random_phase(int items, logic [2:0] nq, logic [7:0] pol, logic [31:0] sl);
      logic [15:0] b;
      write_reg(CSR_QUEUES, {29'd0, nq});
      write_reg(CSR_POLICIES, {24'd0, pol});
      write_reg(CSR_SLICES, sl);
      for (int k = 0; k < items; k++) begin
         if ($urandom_range(99) < 40) begin
            case ($urandom_range(9))
               0: b = 16'hFFFF ^ 16'($urandom_range(65535) & 16'h00FF);
               1: b = 16'($urandom_range(65535));
               2: b = 16'd0;
               default: b = 16'($urandom_range(12, 1));
            endcase
            send(OP_ARRIVE, 4'($urandom_range(15)), 2'($urandom_range(3)), b);
         end else send(OP_TICK, 0, 0, 0);
      end
   endtask

   task automatic test_random();
      random_phase(150, 3'd4, 8'h00, 32'h04040404);
      idle_pct = 0;
      random_phase(150, 3'd2, 8'b10_01_10_01, 32'h02_01_00_03);
      idle_pct = 29;
      random_phase(150, 3'd0, 8'hFF, 32'hFFFFFFFF);
      random_phase(150, 3'd7, 8'($urandom_range(255)), 32'($urandom));
      random_phase(150, 3'd3, 8'b00_10_10_10, 32'h00000000);
      random_phase(150, 3'd1, 8'($urandom_range(255)), 32'h01_02_03_05);
   endtask

   initial begin
      sched_reset();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_policies();
      test_random();
      drain();
      $display("Ran %0d tick beats over several queue counts, policies and slice settings,",
               ticks_seen);
      $display("with arrivals of extreme, random and ignored bursts.");
      if (mismatches == 0 && tick_results.size() == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end
endmodule

// ===== filelist.f =====
sv/mlqs_pkg.sv
sv/mlqs_ram.sv
sv/multilevel_queue_scheduler.sv
test/tb.sv
